// File: hw/rtl/ftvp_pkg.sv
// Shared types, character codes and helper functions of the framed tag/value parser.
package ftvp_pkg;

  localparam logic [7:0] CH_START = 8'h3C;
  localparam logic [7:0] CH_END   = 8'h3E;
  localparam logic [7:0] CH_NAME  = 8'h7C;
  localparam logic [7:0] CH_TAG   = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    SEC_NAME,
    SEC_TAG,
    SEC_VALUE
  } section_t;

  typedef enum logic [2:0] {
    CMD_NAME_CHAR,
    CMD_TAG_CHAR,
    CMD_VALUE_CHAR,
    CMD_LATCH_NAME,
    CMD_LATCH_TAG,
    CMD_CLOSE
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } cmd_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_FINISH
  } bk_state_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: hw/rtl/ftvp_in_if.sv
// Input channel interface carrying one received byte per transaction.
interface ftvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/ftvp_out_if.sv
// Result channel interface carrying one parsed frame per transaction.
interface ftvp_out_if;
  logic               valid;
  logic               ready;
  logic        [63:0] header_text;
  logic        [2:0]  header_length;
  logic signed [31:0] tag_number;
  logic signed [31:0] value_number;

  modport source (output valid, output header_text, output header_length,
                  output tag_number, output value_number, input ready);
  modport sink (input valid, input header_text, input header_length,
                input tag_number, input value_number, output ready);
endinterface

// File: hw/rtl/ftvp_front.sv
// Front end: tracks framing and section and turns each in-frame byte into a back-end command.
module ftvp_front import ftvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ftvp_in_if.sink    rx,
  output logic       push_valid,
  output cmd_entry_t push_entry,
  input  logic       push_ready
);

  logic     in_frame;
  logic     in_frame_next;
  section_t section;
  section_t section_next;
  logic     accept;

  assign rx.ready        = push_ready;
  assign accept          = rx.valid && push_ready;

  always_comb begin
    in_frame_next   = in_frame;
    section_next    = section;
    push_valid      = 1'b0;
    push_entry.cmd  = CMD_NAME_CHAR;
    push_entry.data = rx.rx_byte;
    if (!in_frame) begin
      in_frame_next = (rx.rx_byte == CH_START);
    end else if (rx.rx_byte == CH_END) begin
      push_valid     = rx.valid;
      push_entry.cmd = CMD_CLOSE;
      in_frame_next  = 1'b0;
      section_next   = SEC_NAME;
    end else begin
      push_valid = rx.valid;
      unique case (section)
        SEC_NAME: begin
          if (rx.rx_byte == CH_NAME) begin
            push_entry.cmd = CMD_LATCH_NAME;
            section_next   = SEC_TAG;
          end else begin
            push_entry.cmd = CMD_NAME_CHAR;
          end
        end
        SEC_TAG: begin
          if (rx.rx_byte == CH_TAG) begin
            push_entry.cmd = CMD_LATCH_TAG;
            section_next   = SEC_VALUE;
          end else begin
            push_entry.cmd = CMD_TAG_CHAR;
          end
        end
        default: begin
          push_entry.cmd = CMD_VALUE_CHAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      section  <= SEC_NAME;
    end else if (accept) begin
      in_frame <= in_frame_next;
      section  <= section_next;
    end
  end

endmodule

// File: hw/rtl/ftvp_queue.sv
// Short command queue between the front end and the back end.
module ftvp_queue import ftvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  cmd_entry_t push_entry,
  output logic       push_ready,
  output logic       pop_valid,
  output cmd_entry_t pop_entry,
  input  logic       pop_ready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/ftvp_back.sv
// Back end: character buffers, name latch, sequential number conversion and result register.
module ftvp_back import ftvp_pkg::*; #(
  parameter int BUFFER_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_entry_t q_entry,
  output logic       q_ready,
  ftvp_out_if.source res
);

  localparam int CNT_W = $clog2(BUFFER_CHARS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_CHARS - 1);

  logic [7:0]       name_buf  [BUFFER_CHARS];
  logic [7:0]       tag_buf   [BUFFER_CHARS];
  logic [7:0]       value_buf [BUFFER_CHARS];
  logic [CNT_W-1:0] name_count;
  logic [CNT_W-1:0] tag_count;
  logic [CNT_W-1:0] value_count;
  logic [63:0]      latched_name;
  logic [2:0]       latched_len;
  logic [31:0]      latched_tag;

  bk_state_t state;
  bk_state_t state_next;

  logic             conv_sel;
  logic [CNT_W-1:0] conv_idx;
  logic             conv_neg;
  logic             conv_digits;
  logic [31:0]      conv_acc;
  logic [CNT_W-1:0] conv_cnt;
  logic [7:0]       conv_ch;
  logic             conv_step;
  logic             conv_end;
  logic [31:0]      conv_result;
  logic [31:0]      acc_times_ten;

  logic        char_wr;
  logic        name_latch;
  logic        conv_start;
  logic        tag_done;
  logic        emit;
  logic        slot_free;
  logic        out_valid;
  logic [63:0] packed_name;
  logic [2:0]  packed_len;

  assign slot_free = !out_valid || res.ready;
  assign res.valid = out_valid;

  assign conv_cnt      = conv_sel ? value_count : tag_count;
  assign conv_ch       = conv_sel ? value_buf[conv_idx] : tag_buf[conv_idx];
  assign conv_step     = (conv_idx != conv_cnt) && (is_digit(conv_ch) ||
                         (!conv_digits && (is_blank(conv_ch) || conv_ch == CH_MINUS ||
                                           conv_ch == CH_PLUS)));
  assign conv_end      = !conv_step;
  assign acc_times_ten = {conv_acc[28:0], 3'b000} + {conv_acc[30:0], 1'b0};
  assign conv_result   = conv_neg ? (32'd0 - conv_acc) : conv_acc;

  // The latched name stops at the first zero byte.
  always_comb begin
    logic alive;
    alive       = 1'b1;
    packed_name = '0;
    packed_len  = '0;
    for (int i = 0; i < BUFFER_CHARS; i++) begin
      if (alive && (i < int'(name_count)) && (name_buf[i] != 8'h00)) begin
        packed_name[8*i +: 8] = name_buf[i];
        packed_len            = packed_len + 3'd1;
      end else begin
        alive = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && (q_entry.cmd == CMD_LATCH_TAG || q_entry.cmd == CMD_CLOSE)) begin
          state_next = BK_CONV;
        end
      end
      BK_CONV: begin
        if (conv_end) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (!conv_sel || slot_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready    = 1'b0;
    char_wr    = 1'b0;
    name_latch = 1'b0;
    conv_start = 1'b0;
    tag_done   = 1'b0;
    emit       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_entry.cmd) inside
            CMD_NAME_CHAR, CMD_TAG_CHAR, CMD_VALUE_CHAR: char_wr    = 1'b1;
            CMD_LATCH_NAME:                              name_latch = 1'b1;
            CMD_LATCH_TAG, CMD_CLOSE:                    conv_start = 1'b1;
            default:                                     char_wr    = 1'b0;
          endcase
        end
      end
      BK_CONV: begin
      end
      BK_FINISH: begin
        tag_done = !conv_sel;
        emit     = conv_sel && slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (char_wr) begin
      case (q_entry.cmd)
        CMD_NAME_CHAR: name_buf[name_count]  <= q_entry.data;
        CMD_TAG_CHAR:  tag_buf[tag_count]    <= q_entry.data;
        default:       value_buf[value_count] <= q_entry.data;
      endcase
    end
    if (conv_start) begin
      conv_sel    <= (q_entry.cmd == CMD_CLOSE);
      conv_idx    <= '0;
      conv_neg    <= 1'b0;
      conv_digits <= 1'b0;
      conv_acc    <= '0;
    end else if (state == BK_CONV && conv_step) begin
      conv_idx <= conv_idx + CNT_W'(1);
      if (is_digit(conv_ch)) begin
        conv_acc    <= acc_times_ten + 32'(conv_ch - CH_ZERO);
        conv_digits <= 1'b1;
      end else if (conv_ch == CH_MINUS || conv_ch == CH_PLUS) begin
        conv_neg    <= (conv_ch == CH_MINUS);
        conv_digits <= 1'b1;
      end
    end
    if (emit) begin
      res.header_text   <= latched_name;
      res.header_length <= latched_len;
      res.tag_number    <= latched_tag;
      res.value_number  <= conv_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      name_count   <= '0;
      tag_count    <= '0;
      value_count  <= '0;
      latched_name <= '0;
      latched_len  <= '0;
      latched_tag  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (char_wr) begin
        case (q_entry.cmd)
          CMD_NAME_CHAR: begin
            name_count <= (name_count == CNT_MAX) ? name_count : name_count + CNT_W'(1);
          end
          CMD_TAG_CHAR: begin
            tag_count <= (tag_count == CNT_MAX) ? tag_count : tag_count + CNT_W'(1);
          end
          default: begin
            value_count <= (value_count == CNT_MAX) ? value_count : value_count + CNT_W'(1);
          end
        endcase
      end
      if (name_latch) begin
        latched_name <= packed_name;
        latched_len  <= packed_len;
      end
      if (tag_done) begin
        latched_tag <= conv_result;
      end
      if (emit) begin
        name_count  <= '0;
        tag_count   <= '0;
        value_count <= '0;
        out_valid   <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> res.valid && name_count == '0 && tag_count == '0 && value_count == '0)
    else $error("frame close did not present a result and clear the buffers");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> conv_sel && (!out_valid || res.ready))
    else $error("result register overwritten while still pending");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == BK_CONV |-> conv_idx <= conv_cnt)
    else $error("conversion walked past the buffer fill");

  a_tag_latch: assert property (@(posedge clk) disable iff (rst)
    tag_done |=> latched_tag == $past(conv_result))
    else $error("converted tag not latched");
`endif

endmodule

// File: hw/rtl/framed_tag_value_parser.sv
// Top level of the framed tag/value parser: front end, command queue and back end.
//
//   channel  direction  payload                                             handshake
//   rx       in         rx_byte[7:0]                                        valid/ready
//   res      out        header_text[63:0] header_length[2:0] tag_number,    valid/ready
//                       value_number (signed 32 bits each)
//
// A character or name separator is handled from the idle state; a tag separator or frame close
// starts the conversion walk, one character per cycle, followed by a finish step.
// Bytes outside a frame are taken by the front end alone; the two-entry queue lets the front end
// keep accepting while the back end converts.
// A closed frame waits in the back end until the result register is free.
// Reset is synchronous and clears framing, counts and latched fields; there is no clearing pass.
module framed_tag_value_parser import ftvp_pkg::*; #(
  parameter int BUFFER_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst,
  ftvp_in_if.sink    rx,
  ftvp_out_if.source res
);

  logic       push_valid;
  logic       push_ready;
  cmd_entry_t push_entry;
  logic       pop_valid;
  logic       pop_ready;
  cmd_entry_t pop_entry;

  ftvp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  ftvp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  ftvp_back #(
    .BUFFER_CHARS (BUFFER_CHARS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_entry (pop_entry),
    .q_ready (pop_ready),
    .res     (res)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the framed tag/value parser with directed frames and random byte streams.
module tb_top;
  import ftvp_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int TARGET_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int CHARS        = 8;

  localparam logic [7:0] BLANK_SET [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
  localparam logic [7:0] JUNK_SET [4]  = '{CH_START, "x", ".", CH_NAME};
  localparam logic [7:0] MARK_SET [4]  = '{CH_START, CH_END, CH_NAME, CH_TAG};

  typedef struct packed {
    logic [63:0] header_text;
    logic [2:0]  header_length;
    logic [31:0] tag_number;
    logic [31:0] value_number;
  } frame_result_t;

  typedef struct {
    logic [8*32-1:0] text;
    bit              typed;
    frame_result_t   want;
  } directed_row_t;

  logic clk;
  logic rst;

  ftvp_in_if  rx_ch ();
  ftvp_out_if res_ch ();

  framed_tag_value_parser #(.BUFFER_CHARS(CHARS)) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch)
  );

  frame_result_t pending_frames[$];
  logic [7:0]    burst[$];
  int            errors         = 0;
  int            frames_checked = 0;
  int            bytes_sent     = 0;
  int            framed_items   = 0;
  int            cycles         = 0;
  bit            idle_on        = 1'b1;
  bit            hold_start     = 1'b0;

  bit          framing;
  section_t    cur_section;
  logic [7:0]  char_buf [3][CHARS];
  int          char_cnt [3];
  logic [63:0] held_text;
  logic [2:0]  held_len;
  logic [31:0] held_tag;

  directed_row_t directed_rows [9] = '{
    '{"<|#>", 1'b1, '{64'h0, 3'd0, 32'd0, 32'd0}},
    '{"x>|#<ab|12#-34>", 1'b1, '{64'h6261, 3'd2, 32'd12, -32'sd34}},
    '{"<ABCDEFGHIJ|+12345678#\t 99x>", 1'b0, '0},
    '{"<n\000m|#|>", 1'b0, '0},
    '{"<<#|-#\011+7|#>", 1'b0, '0},
    '{"<q>", 1'b0, '0},
    '{"<\377\200|  -0#\001>", 1'b0, '0},
    '{"<z|-999999#9999999>", 1'b1, '{64'h7A, 3'd1, -32'sd999999, 32'd9999999}},
    '{"<\001|\013\014\015\0127#\011\012->", 1'b0, '0}
  };

  function automatic void store_char(input int s, input logic [7:0] c);
    int idx;
    idx = char_cnt[s] & 7;
    char_buf[s][idx] = c;
    idx++;
    if (idx >= CHARS) idx = CHARS - 1;
    char_cnt[s] = idx;
  endfunction

  function automatic logic [31:0] decimal_of(input int s);
    int          i;
    bit          neg;
    logic [31:0] acc;
    i   = 0;
    neg = 1'b0;
    acc = '0;
    while (i < char_cnt[s] && (char_buf[s][i] == CH_SPACE ||
           (char_buf[s][i] >= CH_TAB && char_buf[s][i] <= CH_CR))) i++;
    if (i < char_cnt[s] && (char_buf[s][i] == CH_MINUS || char_buf[s][i] == CH_PLUS)) begin
      neg = (char_buf[s][i] == CH_MINUS);
      i++;
    end
    while (i < char_cnt[s] && char_buf[s][i] >= CH_ZERO && char_buf[s][i] <= CH_NINE) begin
      acc = acc * 32'd10 + 32'(char_buf[s][i] - CH_ZERO);
      i++;
    end
    return neg ? -acc : acc;
  endfunction

  function automatic bit parse_byte(input logic [7:0] c, output frame_result_t r);
    logic [63:0] text;
    int          len;
    r = '0;
    if (!framing) begin
      framing = (c == CH_START);
      return 1'b0;
    end
    if (c == CH_END) begin
      r.header_text   = held_text;
      r.header_length = held_len;
      r.tag_number    = held_tag;
      r.value_number  = decimal_of(SEC_VALUE);
      framing     = 1'b0;
      cur_section = SEC_NAME;
      char_cnt    = '{0, 0, 0};
      return 1'b1;
    end
    case (cur_section)
      SEC_NAME: begin
        if (c == CH_NAME) begin
          text = '0;
          len  = 0;
          for (int i = 0; i < char_cnt[SEC_NAME]; i++) begin
            if (char_buf[SEC_NAME][i] == 8'h00) break;
            text[8*i +: 8] = char_buf[SEC_NAME][i];
            len++;
          end
          held_text   = text;
          held_len    = len[2:0];
          cur_section = SEC_TAG;
        end else begin
          store_char(SEC_NAME, c);
        end
      end
      SEC_TAG: begin
        if (c == CH_TAG) begin
          held_tag    = decimal_of(SEC_TAG);
          cur_section = SEC_VALUE;
        end else begin
          store_char(SEC_TAG, c);
        end
      end
      default: store_char(SEC_VALUE, c);
    endcase
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
    frame_result_t r;
    while (idle_on && $urandom_range(99) < 16) begin
      rx_ch.valid   = 1'b0;
      rx_ch.rx_byte = 8'($urandom);
      @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    if (framing || b == CH_START) framed_items++;
    bytes_sent++;
    if (parse_byte(b, r)) pending_frames.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic push_number();
    repeat ($urandom_range(2) == 0 ? $urandom_range(1, 2) : 0)
      burst.push_back(BLANK_SET[$urandom_range(5)]);
    case ($urandom_range(4))
      0:       burst.push_back(CH_MINUS);
      1:       burst.push_back(CH_PLUS);
      default: ;
    endcase
    repeat ($urandom_range(8)) burst.push_back(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(4) == 0) burst.push_back(JUNK_SET[$urandom_range(3)]);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles without finishing.", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else begin
        res_ch.ready = !(idle_on && $urandom_range(99) < 16);
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t oldest;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame result: header_text %h", res_ch.header_text);
        errors++;
      end else begin
        oldest = pending_frames.pop_front();
        frames_checked++;
        if (res_ch.header_text !== oldest.header_text) begin
          $error("header_text: expected %h, got %h", oldest.header_text, res_ch.header_text);
          errors++;
        end
        if (res_ch.header_length !== oldest.header_length) begin
          $error("header_length: expected %0d, got %0d", oldest.header_length,
                 res_ch.header_length);
          errors++;
        end
        if (res_ch.tag_number !== oldest.tag_number) begin
          $error("tag_number: expected %0d, got %0d", $signed(oldest.tag_number),
                 res_ch.tag_number);
          errors++;
        end
        if (res_ch.value_number !== oldest.value_number) begin
          $error("value_number: expected %0d, got %0d", $signed(oldest.value_number),
                 res_ch.value_number);
          errors++;
        end
      end
    end
  end

  initial begin
    int         n;
    int         roll;
    logic [7:0] c;
    bit         hold_done;
    bit         drain_done;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    framing       = 1'b0;
    cur_section   = SEC_NAME;
    char_cnt      = '{0, 0, 0};
    held_text     = '0;
    held_len      = '0;
    held_tag      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[k]) begin
      n = 32;
      while (n > 0 && directed_rows[k].text[8*(n-1) +: 8] == 8'h00) n--;
      for (int j = n - 1; j >= 0; j--)
        send_byte(directed_rows[k].text[8*j +: 8], directed_rows[k].typed, directed_rows[k].want);
    end

    while (framed_items < TARGET_ITEMS) begin
      if (framed_items >= 300 && !hold_done) begin
        hold_start = 1'b1;
        hold_done  = 1'b1;
      end
      if (framed_items >= 1000 && !drain_done) begin
        drain_done  = 1'b1;
        rx_ch.valid = 1'b0;
        while (pending_frames.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
      end
      idle_on = !(framed_items >= 600 && framed_items < 850);
      roll = $urandom_range(99);
      if (roll < 10) begin
        repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom));
      end else if (roll < 22) begin
        burst.push_back(CH_START);
        repeat ($urandom_range(1, 14))
          burst.push_back($urandom_range(9) < 4 ? MARK_SET[$urandom_range(3)] : 8'($urandom));
      end else begin
        burst.push_back(CH_START);
        repeat ($urandom_range(9)) begin
          roll = $urandom_range(99);
          if (roll < 75) c = "a" + 8'($urandom_range(25));
          else if (roll < 85) c = 8'($urandom);
          else if (roll < 93) c = roll[0] ? CH_START : CH_TAG;
          else c = 8'h00;
          if (c == CH_NAME || c == CH_END) c = "z";
          burst.push_back(c);
        end
        if ($urandom_range(19) != 0) burst.push_back(CH_NAME);
        push_number();
        if ($urandom_range(19) != 0) burst.push_back(CH_TAG);
        push_number();
        burst.push_back(CH_END);
      end
      foreach (burst[k]) send_byte(burst[k], 1'b0, '0);
      burst.delete();
    end

    rx_ch.valid = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d bytes (%0d inside frames) and checked %0d frame results.",
             bytes_sent, framed_items, frames_checked);
    $display("Covered a %0d-cycle result hold-off, a full drain pause and an idle-free stretch.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
